// ----- design/kvtu8_pkg.sv -----
// ----------------------------------------------------------------------------
// kvtu8_pkg
// Shared types, constants and encoding helpers of the key event to VT / UTF-8
// byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kvtu8_pkg;

  // byte buffer sizing
  localparam int MaxBytes = 8;
  localparam int CntW     = $clog2(MaxBytes + 1);
  localparam int IdxW     = $clog2(MaxBytes);

  // output byte codes
  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChUpperO = 8'h4F;
  localparam logic [7:0] ChUpperP = 8'h50;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChNone   = 8'h00;

  // code points
  localparam logic [20:0] CpRepl     = 21'h00FFFD;
  localparam logic [20:0] CpSuppBase = 21'h010000;
  localparam logic [5:0]  SurrHiTag  = 6'b110110;
  localparam logic [5:0]  SurrLoTag  = 6'b110111;

  // virtual-key codes
  localparam logic [7:0] VkBack   = 8'h08;
  localparam logic [7:0] VkPrior  = 8'h21;
  localparam logic [7:0] VkNext   = 8'h22;
  localparam logic [7:0] VkEnd    = 8'h23;
  localparam logic [7:0] VkHome   = 8'h24;
  localparam logic [7:0] VkLeft   = 8'h25;
  localparam logic [7:0] VkUp     = 8'h26;
  localparam logic [7:0] VkRight  = 8'h27;
  localparam logic [7:0] VkDown   = 8'h28;
  localparam logic [7:0] VkInsert = 8'h2D;
  localparam logic [7:0] VkDelete = 8'h2E;
  localparam logic [7:0] VkF1     = 8'h70;
  localparam logic [7:0] VkF2     = 8'h71;
  localparam logic [7:0] VkF3     = 8'h72;
  localparam logic [7:0] VkF4     = 8'h73;
  localparam logic [7:0] VkF5     = 8'h74;
  localparam logic [7:0] VkF6     = 8'h75;
  localparam logic [7:0] VkF7     = 8'h76;
  localparam logic [7:0] VkF8     = 8'h77;
  localparam logic [7:0] VkF9     = 8'h78;
  localparam logic [7:0] VkF10    = 8'h79;
  localparam logic [7:0] VkF11    = 8'h7A;
  localparam logic [7:0] VkF12    = 8'h7B;

  typedef enum logic [1:0] {
    KindText,
    KindCsiFinal,
    KindCsiTilde,
    KindSs3
  } key_kind_e;

  typedef struct packed {
    key_kind_e  kind;
    logic [7:0] fin;
    logic [7:0] tens;
    logic [7:0] ones;
  } key_info_t;

  typedef struct packed {
    logic        key_down;
    logic [7:0]  key_code;
    logic [15:0] char_unit;
    logic        shift_held;
    logic        alt_held;
    logic        ctrl_held;
  } key_evt_t;

  typedef struct packed {
    logic       pending_high;
    logic [9:0] held_high_bits;
    logic       held_high_alt;
  } surr_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } byte_buf_t;

  typedef struct packed {
    byte_buf_t seq;
    surr_t     surr_next;
  } enc_res_t;

  // special key lookup
  function automatic key_info_t key_lookup(logic [7:0] vk);
    key_info_t info;
    info = '{kind: KindText, fin: ChNone, tens: ChNone, ones: ChNone};
    case (vk)
      VkUp:     begin info.kind = KindCsiFinal; info.fin  = 8'h41; end
      VkDown:   begin info.kind = KindCsiFinal; info.fin  = 8'h42; end
      VkRight:  begin info.kind = KindCsiFinal; info.fin  = 8'h43; end
      VkLeft:   begin info.kind = KindCsiFinal; info.fin  = 8'h44; end
      VkHome:   begin info.kind = KindCsiFinal; info.fin  = 8'h48; end
      VkEnd:    begin info.kind = KindCsiFinal; info.fin  = 8'h46; end
      VkInsert: begin info.kind = KindCsiTilde; info.ones = 8'h32; end
      VkDelete: begin info.kind = KindCsiTilde; info.ones = 8'h33; end
      VkPrior:  begin info.kind = KindCsiTilde; info.ones = 8'h35; end
      VkNext:   begin info.kind = KindCsiTilde; info.ones = 8'h36; end
      VkF5: begin info.kind = KindCsiTilde; info.tens = 8'h31; info.ones = 8'h35; end
      VkF6: begin info.kind = KindCsiTilde; info.tens = 8'h31; info.ones = 8'h37; end
      VkF7: begin info.kind = KindCsiTilde; info.tens = 8'h31; info.ones = 8'h38; end
      VkF8: begin info.kind = KindCsiTilde; info.tens = 8'h31; info.ones = 8'h39; end
      VkF9: begin info.kind = KindCsiTilde; info.tens = 8'h32; info.ones = 8'h30; end
      VkF10: begin info.kind = KindCsiTilde; info.tens = 8'h32; info.ones = 8'h31; end
      VkF11: begin info.kind = KindCsiTilde; info.tens = 8'h32; info.ones = 8'h33; end
      VkF12: begin info.kind = KindCsiTilde; info.tens = 8'h32; info.ones = 8'h34; end
      VkF1, VkF2, VkF3, VkF4: begin
        info.kind = KindSs3;
        info.fin  = ChUpperP + {6'b0, vk[1:0]};
      end
      default: info.kind = KindText;
    endcase
    return info;
  endfunction

  // append one byte to a sequence
  function automatic byte_buf_t put(byte_buf_t acc, logic [7:0] b);
    byte_buf_t r;
    r = acc;
    if (acc.count < CntW'(MaxBytes)) begin
      r.bytes[acc.count[IdxW-1:0]] = b;
      r.count = acc.count + CntW'(1);
    end
    return r;
  endfunction

  // append a code point as utf-8
  function automatic byte_buf_t put_utf8(byte_buf_t acc, logic [20:0] cp);
    byte_buf_t r;
    r = acc;
    if (cp < 21'h80) begin
      r = put(r, cp[7:0]);
    end else if (cp < 21'h800) begin
      r = put(r, {3'b110, cp[10:6]});
      r = put(r, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      r = put(r, {4'b1110, cp[15:12]});
      r = put(r, {2'b10, cp[11:6]});
      r = put(r, {2'b10, cp[5:0]});
    end else begin
      r = put(r, {5'b11110, cp[20:18]});
      r = put(r, {2'b10, cp[17:12]});
      r = put(r, {2'b10, cp[11:6]});
      r = put(r, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/kvtu8_key_if.sv -----
// ----------------------------------------------------------------------------
// kvtu8_key_if
// Valid/ready channel that carries one key event per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvtu8_key_if;
  logic        valid;
  logic        ready;
  logic        key_down;
  logic [7:0]  key_code;
  logic [15:0] char_unit;
  logic        shift_held;
  logic        alt_held;
  logic        ctrl_held;

  modport source (
    output valid, key_down, key_code, char_unit, shift_held, alt_held, ctrl_held,
    input  ready
  );

  modport sink (
    input  valid, key_down, key_code, char_unit, shift_held, alt_held, ctrl_held,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/kvtu8_byte_if.sv -----
// ----------------------------------------------------------------------------
// kvtu8_byte_if
// Valid/ready channel that carries one output byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvtu8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/kvtu8_encoder.sv -----
// ----------------------------------------------------------------------------
// kvtu8_encoder
// Turns one registered key event and the held surrogate state into the full
// byte sequence of the event and the next surrogate state.
// ----------------------------------------------------------------------------
`default_nettype none

module kvtu8_encoder (
  input  kvtu8_pkg::key_evt_t evt_i,
  input  kvtu8_pkg::surr_t    surr_i,
  output kvtu8_pkg::enc_res_t res_o
);

  kvtu8_pkg::key_info_t info;
  kvtu8_pkg::byte_buf_t acc;
  kvtu8_pkg::surr_t     surr_d;
  logic [3:0]           mod;
  logic [7:0]           mod_char;
  logic                 has_mod;
  logic                 is_hi;
  logic                 is_lo;
  logic                 is_ctl;
  logic [20:0]          joined_cp;

  // key classification
  assign info      = kvtu8_pkg::key_lookup(evt_i.key_code);
  assign mod       = {evt_i.ctrl_held, evt_i.alt_held, evt_i.shift_held} + 4'd1;
  assign mod_char  = kvtu8_pkg::ChZero + {4'b0, mod};
  assign has_mod   = evt_i.ctrl_held | evt_i.alt_held | evt_i.shift_held;
  assign is_hi     = evt_i.char_unit[15:10] == kvtu8_pkg::SurrHiTag;
  assign is_lo     = evt_i.char_unit[15:10] == kvtu8_pkg::SurrLoTag;
  assign is_ctl    = (evt_i.char_unit < 16'(kvtu8_pkg::ChSpace)) ||
                     (evt_i.char_unit == 16'(kvtu8_pkg::ChDel));
  assign joined_cp = kvtu8_pkg::CpSuppBase +
                     {1'b0, surr_i.held_high_bits, evt_i.char_unit[9:0]};

  // byte sequence build
  always_comb begin
    acc    = '0;
    surr_d = surr_i;
    if (evt_i.key_down) begin
      case (info.kind)
        kvtu8_pkg::KindSs3: begin
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChUpperO);
          acc = kvtu8_pkg::put(acc, info.fin);
        end
        kvtu8_pkg::KindCsiFinal: begin
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChLBrack);
          if (has_mod) begin
            acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChOne);
            acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChSemi);
            acc = kvtu8_pkg::put(acc, mod_char);
          end
          acc = kvtu8_pkg::put(acc, info.fin);
        end
        kvtu8_pkg::KindCsiTilde: begin
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChLBrack);
          if (info.tens != kvtu8_pkg::ChNone) begin
            acc = kvtu8_pkg::put(acc, info.tens);
          end
          acc = kvtu8_pkg::put(acc, info.ones);
          if (has_mod) begin
            acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChSemi);
            acc = kvtu8_pkg::put(acc, mod_char);
          end
          acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChTilde);
        end
        default: begin
          if (evt_i.char_unit == 16'h0000) begin
            // key without a character gives nothing
          end else if (evt_i.key_code == kvtu8_pkg::VkBack) begin
            if (evt_i.alt_held) acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
            acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChDel);
          end else if (is_ctl) begin
            if (evt_i.alt_held) acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
            acc = kvtu8_pkg::put(acc, {1'b0, evt_i.char_unit[6:0]});
          end else if (is_hi) begin
            // flush any older held unit, then hold this one
            if (surr_i.pending_high) begin
              if (surr_i.held_high_alt) acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
              acc = kvtu8_pkg::put_utf8(acc, kvtu8_pkg::CpRepl);
            end
            surr_d.pending_high   = 1'b1;
            surr_d.held_high_bits = evt_i.char_unit[9:0];
            surr_d.held_high_alt  = evt_i.alt_held;
          end else if (is_lo) begin
            if (surr_i.pending_high) begin
              if (evt_i.alt_held || surr_i.held_high_alt) begin
                acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
              end
              acc = kvtu8_pkg::put_utf8(acc, joined_cp);
              surr_d.pending_high = 1'b0;
            end else begin
              if (evt_i.alt_held) acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
              acc = kvtu8_pkg::put_utf8(acc, kvtu8_pkg::CpRepl);
            end
          end else begin
            // plain character, after flushing a stray held unit
            if (surr_i.pending_high) begin
              if (surr_i.held_high_alt) acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
              acc = kvtu8_pkg::put_utf8(acc, kvtu8_pkg::CpRepl);
              surr_d.pending_high = 1'b0;
            end
            if (evt_i.alt_held) acc = kvtu8_pkg::put(acc, kvtu8_pkg::ChEsc);
            acc = kvtu8_pkg::put_utf8(acc, {5'b0, evt_i.char_unit});
          end
        end
      endcase
    end
  end

  assign res_o.seq       = acc;
  assign res_o.surr_next = surr_d;

endmodule

`default_nettype wire

// ----- design/key_event_to_vt_utf8_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// key_event_to_vt_utf8_encoder_unit: key event to VT / UTF-8 byte stream
// Path: input register, combinational encoder, then the byte register.
// Throughput: one byte per cycle while byte_o.ready is high; an event occupies
// the byte register until its last byte is taken, one with no bytes is not loaded.
// Reset: asynchronous, clears both valid flags and the held surrogate state.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_to_vt_utf8_encoder_unit (
  input  wire            clk_i,
  input  wire            rst_ni,
  kvtu8_key_if.sink      key_i,
  kvtu8_byte_if.source   byte_o
);

  logic                      in_valid_q;
  kvtu8_pkg::key_evt_t       in_evt_q;
  kvtu8_pkg::key_evt_t       in_evt_d;
  kvtu8_pkg::surr_t          surr_q;
  kvtu8_pkg::enc_res_t       enc;
  logic                      out_valid_q;
  logic [kvtu8_pkg::MaxBytes-1:0][7:0] out_bytes_q;
  logic [kvtu8_pkg::CntW-1:0] out_cnt_q;
  logic [kvtu8_pkg::IdxW-1:0] out_idx_q;
  logic                      out_last;
  logic                      out_take;
  logic                      out_free;
  logic                      in_adv;
  logic                      load;
  logic                      in_take;

  // input transaction payload
  assign in_evt_d = '{key_down:   key_i.key_down,
                      key_code:   key_i.key_code,
                      char_unit:  key_i.char_unit,
                      shift_held: key_i.shift_held,
                      alt_held:   key_i.alt_held,
                      ctrl_held:  key_i.ctrl_held};

  kvtu8_encoder u_encoder (
    .evt_i  (in_evt_q),
    .surr_i (surr_q),
    .res_o  (enc)
  );

  // handshake control
  assign out_last = ({1'b0, out_idx_q} + kvtu8_pkg::CntW'(1)) == out_cnt_q;
  assign out_take = out_valid_q && byte_o.ready;
  assign out_free = !out_valid_q || (out_take && out_last);
  assign in_adv   = in_valid_q && ((enc.seq.count == '0) || out_free);
  assign load     = in_adv && (enc.seq.count != '0);
  assign key_i.ready = !in_valid_q || in_adv;
  assign in_take  = key_i.valid && key_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (in_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_evt_q <= in_evt_d;
    end
  end

  // surrogate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surr_q <= '0;
    end else if (in_adv) begin
      surr_q <= enc.surr_next;
    end
  end

  // output byte register and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_cnt_q   <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= '0;
      out_cnt_q   <= enc.seq.count;
    end else if (out_take) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        out_idx_q <= out_idx_q + kvtu8_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_bytes_q <= enc.seq.bytes;
    end
  end

  assign byte_o.valid     = out_valid_q;
  assign byte_o.out_byte  = out_bytes_q[out_idx_q];
  assign byte_o.last_byte = out_last;

`ifndef NO_ASSERTIONS
  // the byte index stays inside a loaded, non-empty sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q != '0) && ({1'b0, out_idx_q} < out_cnt_q))
    else $error("output index beyond sequence length");

  // a surrogate becomes held only from a high surrogate unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(surr_q.pending_high) |->
      $past(in_adv && in_evt_q.key_down &&
            (in_evt_q.char_unit[15:10] == kvtu8_pkg::SurrHiTag)))
    else $error("surrogate held without a high unit");

  // after the final byte goes out with nothing new loaded the output empties
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && out_last && !load) |=> !byte_o.valid)
    else $error("output still valid after final byte");

  // a release never changes the surrogate state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && !in_evt_q.key_down) |=> $stable(surr_q))
    else $error("key release changed surrogate state");
`endif

endmodule

`default_nettype wire
